>>> rtl/cnsp_pkg.sv
// shared types, character codes and hex decoding for the numeric color spec parser
// no dependencies; imported by every module of the block
package cnsp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } cnsp_in_t;

  typedef struct packed {
    logic        matched;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
  } cnsp_out_t;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_HASH   = 5'b00010,
    PH_PREFIX = 5'b00100,
    PH_FIELD  = 5'b01000,
    PH_DONE   = 5'b10000
  } cnsp_phase_t;

  typedef struct packed {
    cnsp_phase_t phase;
    logic [1:0]  prefix_seen;
    logic [47:0] hash_nibbles;
    logic [3:0]  hash_count;
    logic [1:0]  field_index;
    logic [2:0]  field_digits;
    logic [15:0] field_value;
    logic [15:0] red_hold;
    logic [15:0] green_hold;
    logic        failed;
  } cnsp_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } cnsp_hex_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [3:0] HASH_MAX_DIGITS  = 4'd12;
  localparam logic [2:0] FIELD_MAX_DIGITS = 3'd4;
  localparam logic [1:0] PREFIX_LEN       = 2'd3;

  localparam logic [1:0] FIELD_RED   = 2'd0;
  localparam logic [1:0] FIELD_GREEN = 2'd1;
  localparam logic [1:0] FIELD_BLUE  = 2'd2;

  // 2^20/273 rounded up; (v*3841)>>20 == v/273 for v < 4096
  localparam logic [11:0] DIV273_RECIP = 12'd3841;

  localparam cnsp_state_t STATE_IDLE = '{
    phase: PH_START, prefix_seen: '0, hash_nibbles: '0, hash_count: '0,
    field_index: '0, field_digits: '0, field_value: '0, red_hold: '0,
    green_hold: '0, failed: 1'b0
  };

  function automatic cnsp_hex_t hex_decode(input logic [7:0] c);
    cnsp_hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h61 + 8'd10);
    end
    return h;
  endfunction

  // characters of the optional "rgb" prefix
  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h72;
      2'd1:    c = 8'h67;
      2'd2:    c = 8'h62;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/cnsp_field_scale.sv
// scales a 1 to 4 digit hex field to a 16-bit level, truncating
// depends on cnsp_pkg
module cnsp_field_scale
  import cnsp_pkg::*;
(
  input  logic [15:0] value,
  input  logic [2:0]  digits,
  output logic        ok,
  output logic [15:0] level
);

  logic [23:0] prod;
  logic [3:0]  quot;

  // 3 digits: v*65535/4095 = 16v + v/273
  assign prod = 24'(value[11:0]) * 24'(DIV273_RECIP);
  assign quot = prod[23:20];

  always_comb begin
    ok    = 1'b1;
    level = value;
    unique case (digits)
      3'd1:    level = {4{value[3:0]}};
      3'd2:    level = {2{value[7:0]}};
      3'd3:    level = {value[11:0], quot};
      3'd4:    level = value;
      default: begin
        ok    = 1'b0;
        level = value;
      end
    endcase
  end

endmodule

>>> rtl/cnsp_step.sv
// one character of parsing: next parser state and the result for a final character
// depends on cnsp_pkg and cnsp_field_scale
module cnsp_step
  import cnsp_pkg::*;
(
  input  cnsp_state_t cur,
  input  cnsp_in_t    item,
  output cnsp_state_t nxt,
  output cnsp_out_t   res
);

  cnsp_hex_t   hex;
  logic        dig_app;
  logic [15:0] app_value;
  logic [2:0]  app_digits;
  logic [15:0] sc_value;
  logic [2:0]  sc_digits;
  logic        sc_ok;
  logic [15:0] sc_level;

  assign hex        = hex_decode(item.char_code);
  assign app_value  = {cur.field_value[11:0], hex.val};
  assign app_digits = cur.field_digits + 3'd1;
  // digit appended to the open field this cycle
  assign dig_app    = (cur.phase == PH_FIELD) && hex.ok &&
                      (cur.field_digits < FIELD_MAX_DIGITS);
  assign sc_value   = dig_app ? app_value  : cur.field_value;
  assign sc_digits  = dig_app ? app_digits : cur.field_digits;

  cnsp_field_scale u_scale (
    .value  (sc_value),
    .digits (sc_digits),
    .ok     (sc_ok),
    .level  (sc_level)
  );

  always_comb begin
    cnsp_state_t t;
    cnsp_phase_t ph;
    logic        skip;
    logic        do_end;
    t      = cur;
    ph     = cur.phase;
    skip   = 1'b0;
    do_end = 1'b0;

    if (cur.phase != PH_DONE) begin
      if (item.char_code == CH_NUL) begin
        do_end = 1'b1;
      end else begin
        if (ph == PH_START) begin
          if (item.char_code == CH_HASH) begin
            t.phase = PH_HASH;
            skip    = 1'b1;
          end else begin
            ph      = PH_PREFIX;
            t.phase = PH_PREFIX;
          end
        end
        if (!skip) begin
          if (ph == PH_HASH) begin
            if (!hex.ok || cur.hash_count >= HASH_MAX_DIGITS) begin
              t.failed = 1'b1;
              t.phase  = PH_DONE;
            end else begin
              t.hash_nibbles = {cur.hash_nibbles[43:0], hex.val};
              t.hash_count   = cur.hash_count + 4'd1;
            end
          end else if (ph == PH_PREFIX) begin
            if (item.char_code == CH_COLON) begin
              t.phase        = PH_FIELD;
              t.field_index  = FIELD_RED;
              t.field_digits = '0;
              t.field_value  = '0;
            end else if (cur.prefix_seen < PREFIX_LEN &&
                         item.char_code == prefix_char(cur.prefix_seen)) begin
              t.prefix_seen = cur.prefix_seen + 2'd1;
            end else begin
              t.failed = 1'b1;
              t.phase  = PH_DONE;
            end
          end else if (ph == PH_FIELD) begin
            if (item.char_code == CH_SLASH) begin
              if (!sc_ok) begin
                t.failed = 1'b1;
                t.phase  = PH_DONE;
              end else if (cur.field_index >= FIELD_BLUE) begin
                t.field_value = sc_level;
                t.phase       = PH_DONE;
              end else begin
                if (cur.field_index == FIELD_RED) begin
                  t.red_hold = sc_level;
                end else begin
                  t.green_hold = sc_level;
                end
                t.field_index  = cur.field_index + 2'd1;
                t.field_digits = '0;
                t.field_value  = '0;
              end
            end else if (!dig_app) begin
              t.failed = 1'b1;
              t.phase  = PH_DONE;
            end else begin
              t.field_value  = app_value;
              t.field_digits = app_digits;
            end
          end
        end
      end
    end

    if (item.is_last && t.phase != PH_DONE) begin
      do_end = 1'b1;
    end

    // end of spec: settle hash digits or the last field; any other open phase fails
    if (do_end) begin
      if (t.phase == PH_HASH) begin
        t.phase = PH_DONE;
        unique case (t.hash_count)
          4'd3: begin
            t.red_hold    = {t.hash_nibbles[11:8], 12'd0};
            t.green_hold  = {t.hash_nibbles[7:4], 12'd0};
            t.field_value = {t.hash_nibbles[3:0], 12'd0};
          end
          4'd6: begin
            t.red_hold    = {t.hash_nibbles[23:16], 8'd0};
            t.green_hold  = {t.hash_nibbles[15:8], 8'd0};
            t.field_value = {t.hash_nibbles[7:0], 8'd0};
          end
          4'd9: begin
            t.red_hold    = {t.hash_nibbles[35:24], 4'd0};
            t.green_hold  = {t.hash_nibbles[23:12], 4'd0};
            t.field_value = {t.hash_nibbles[11:0], 4'd0};
          end
          4'd12: begin
            t.red_hold    = t.hash_nibbles[47:32];
            t.green_hold  = t.hash_nibbles[31:16];
            t.field_value = t.hash_nibbles[15:0];
          end
          default: t.failed = 1'b1;
        endcase
      end else if (t.phase == PH_FIELD) begin
        t.phase = PH_DONE;
        // a slash that just opened the blue field leaves it empty
        if (t.field_index != FIELD_BLUE || t.field_digits == 3'd0 || !sc_ok) begin
          t.failed = 1'b1;
        end else begin
          t.field_value = sc_level;
        end
      end else if (t.phase != PH_DONE) begin
        t.failed = 1'b1;
        t.phase  = PH_DONE;
      end
    end

    res.matched     = !t.failed;
    res.red_level   = t.failed ? 16'd0 : t.red_hold;
    res.green_level = t.failed ? 16'd0 : t.green_hold;
    res.blue_level  = t.failed ? 16'd0 : t.field_value;

    nxt = item.is_last ? STATE_IDLE : t;
  end

endmodule

>>> rtl/numeric_color_spec_parser.sv
// top level of the numeric color spec parser: input register, parser state, result register
// depends on cnsp_pkg and cnsp_step
//
// The block reads a color spec one character per transaction, is_last on the final
// character, and gives one result transaction for each spec: matched plus 16-bit red,
// green and blue. Accepted forms are '#' with 3, 6, 9 or 12 hex digits (three equal groups,
// each left-justified to 16 bits) and an optional leading part of "rgb" (case-sensitive)
// followed by ':' and three '/'-separated hex fields of 1 to 4 digits, each scaled to
// v*65535/(16^n-1) truncated; text after the third field's '/' is ignored. A zero byte ends
// the spec early. Anything malformed gives matched=0 with all levels zero. Throughput is one
// character per clock: a character goes from the input register through the combinational
// parse step into the parser state, and a final character also loads the result register,
// so the result is registered as its last character leaves the input register. in_stall rises
// only when a final character waits behind a result that the consumer is stalling; other
// characters keep flowing while a result waits.
module numeric_color_spec_parser
  import cnsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cnsp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cnsp_out_t out_data
);

  // input stage
  logic        in_vld_r;
  cnsp_in_t    in_item_r;
  // parser state
  cnsp_state_t state_r;
  cnsp_state_t state_nxt;
  // result stage
  logic        out_vld_r;
  cnsp_out_t   out_item_r;
  cnsp_out_t   res_nxt;

  logic        blocked;
  logic        advance;

  // a final character can only move on when the result register is free or being taken
  assign blocked  = in_vld_r && in_item_r.is_last && out_vld_r && out_stall;
  assign advance  = in_vld_r && !blocked;
  assign in_stall = blocked;

  cnsp_step u_step (
    .cur  (state_r),
    .item (in_item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!blocked) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !blocked) begin
      in_item_r <= in_data;
    end
  end

  // parser state, returns to idle after each final character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_IDLE;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && in_item_r.is_last) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_item_r.is_last) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

>>> rtl/cnsp_checker.sv
// port-level checks for the numeric color spec parser, bound to the top level
// depends on cnsp_pkg and numeric_color_spec_parser
module cnsp_checker
  import cnsp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input cnsp_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input cnsp_out_t out_data
);

  // stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transaction changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // a rejected spec carries zero levels
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.matched |->
      out_data.red_level == 16'd0 && out_data.green_level == 16'd0 &&
      out_data.blue_level == 16'd0)
    else $error("unmatched result with nonzero levels");

  // input side only waits on a stalled consumer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind numeric_color_spec_parser cnsp_checker u_cnsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> test/tb_top.sv
// self-checking testbench for numeric_color_spec_parser: random and directed color specs
// depends on cnsp_pkg and the block's rtl; holds its own model of the spec parser
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cnsp_pkg::*;

  // characters the stimulus and the predictor care about
  localparam logic [7:0] CH_DIGIT_0 = "0";
  localparam logic [7:0] CH_DIGIT_9 = "9";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_UPPER_F = "F";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_F = "f";
  localparam logic [7:0] CH_R       = "r";
  localparam logic [7:0] CH_G       = "g";
  localparam logic [7:0] CH_B       = "b";
  localparam logic [7:0] CH_TOP     = 8'hFF;
  localparam logic [23:0] RGB_WORD  = {CH_R, CH_G, CH_B};

  localparam int NOT_HEX = -1;

  // field scaling to 16 bits: v*65535/(16^n-1)
  localparam logic [31:0] SCALE_ONE_DIGIT   = 32'd4369;
  localparam logic [31:0] SCALE_TWO_DIGITS  = 32'd257;
  localparam logic [31:0] FULL_LEVEL        = 32'hFFFF;
  localparam logic [31:0] THREE_DIGIT_SPAN  = 32'd4095;

  localparam int ITEM_TARGET  = 1050;  // minimum number of characters to send in total
  localparam int TAIL_CHARS   = 120;   // no sender idling for the last characters
  localparam int TAIL_SPECS   = 12;    // no receiver stalls for the last results
  localparam int STUCK_LIMIT  = 1000;  // cycles with no transaction before giving up
  localparam int SETTLE_ITEMS = 8;     // clocks to run on after the last expected result

  typedef struct packed {
    logic     hold_for_drain;  // wait for every pending result before sending this one
    cnsp_in_t item;
  } feed_entry_t;

  typedef enum {
    DMG_REPLACE, DMG_NUL, DMG_DROP, DMG_REPEAT, DMG_CUT
  } spec_damage_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  cnsp_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  cnsp_out_t out_data;

  numeric_color_spec_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // spec parser model: state mirrors the block, updated per accepted character
  // ---------------------------------------------------------------------------
  cnsp_phase_t sp_phase;
  logic [2:0]  sp_prefix_len;
  logic [47:0] sp_nibbles;
  logic [3:0]  sp_hex_count;
  logic [1:0]  sp_field;
  logic [2:0]  sp_digits;
  logic [15:0] sp_value;       // current field; blue once the spec is decided
  logic [15:0] sp_red;
  logic [15:0] sp_green;
  logic        sp_failed;

  cnsp_out_t   expected_colors[$];

  function automatic void clear_spec_state();
    sp_phase      = PH_START;
    sp_prefix_len = '0;
    sp_nibbles    = '0;
    sp_hex_count  = '0;
    sp_field      = '0;
    sp_digits     = '0;
    sp_value      = '0;
    sp_red        = '0;
    sp_green      = '0;
    sp_failed     = 1'b0;
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return c - CH_DIGIT_0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return c - CH_UPPER_A + 10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return c - CH_LOWER_A + 10;
    return NOT_HEX;
  endfunction

  function automatic void reject_spec();
    sp_failed = 1'b1;
    sp_phase  = PH_DONE;
  endfunction

  // scale the finished field in place; an empty field is an error
  function automatic bit close_field();
    logic [31:0] v;
    v = {16'd0, sp_value};
    if (sp_digits == 3'd0) return 1'b0;
    case (sp_digits)
      3'd1:    v = v * SCALE_ONE_DIGIT;
      3'd2:    v = v * SCALE_TWO_DIGITS;
      3'd3:    v = (v * FULL_LEVEL) / THREE_DIGIT_SPAN;
      default: ;
    endcase
    sp_value = v[15:0];
    return 1'b1;
  endfunction

  function automatic void finish_spec();
    int unsigned groups;
    int unsigned bits;
    logic [47:0] mask;
    logic [47:0] level;
    if (sp_phase == PH_HASH) begin
      groups = sp_hex_count / 3;
      if (sp_failed || groups == 0 || sp_hex_count != groups * 3) begin
        reject_spec();
        return;
      end
      bits     = 4 * groups;
      mask     = (48'd1 << bits) - 48'd1;
      level    = (sp_nibbles & mask) << (16 - bits);
      sp_value = level[15:0];
      level    = ((sp_nibbles >> bits) & mask) << (16 - bits);
      sp_green = level[15:0];
      level    = ((sp_nibbles >> (2 * bits)) & mask) << (16 - bits);
      sp_red   = level[15:0];
      sp_phase = PH_DONE;
    end else if (sp_phase == PH_FIELD) begin
      if (sp_field != FIELD_BLUE || !close_field()) begin
        reject_spec();
        return;
      end
      sp_phase = PH_DONE;
    end else if (sp_phase != PH_DONE) begin
      reject_spec();
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    int d;
    if (sp_phase == PH_DONE) return;
    if (c == CH_NUL) begin
      finish_spec();
      return;
    end
    if (sp_phase == PH_START) begin
      if (c == CH_HASH) begin
        sp_phase = PH_HASH;
        return;
      end
      sp_phase = PH_PREFIX;
    end
    d = hex_value(c);
    if (sp_phase == PH_HASH) begin
      if (d == NOT_HEX || sp_hex_count >= HASH_MAX_DIGITS) begin
        reject_spec();
        return;
      end
      sp_nibbles   = {sp_nibbles[43:0], 4'(d)};
      sp_hex_count = sp_hex_count + 4'd1;
    end else if (sp_phase == PH_PREFIX) begin
      if (c == CH_COLON) begin
        sp_phase  = PH_FIELD;
        sp_field  = FIELD_RED;
        sp_digits = '0;
        sp_value  = '0;
      end else if (sp_prefix_len < PREFIX_LEN && c == RGB_WORD[23 - 8 * sp_prefix_len -: 8]) begin
        sp_prefix_len = sp_prefix_len + 3'd1;
      end else begin
        reject_spec();
      end
    end else if (sp_phase == PH_FIELD) begin
      if (c == CH_SLASH) begin
        if (!close_field()) begin
          reject_spec();
          return;
        end
        if (sp_field == FIELD_RED) sp_red = sp_value;
        else if (sp_field == FIELD_GREEN) sp_green = sp_value;
        if (sp_field >= FIELD_BLUE) begin
          sp_phase = PH_DONE;
          return;
        end
        sp_field  = sp_field + 2'd1;
        sp_digits = '0;
        sp_value  = '0;
        return;
      end
      if (sp_digits >= FIELD_MAX_DIGITS || d == NOT_HEX) begin
        reject_spec();
        return;
      end
      sp_value  = {sp_value[11:0], 4'(d)};
      sp_digits = sp_digits + 3'd1;
    end
  endfunction

  // one accepted character; the final one of a spec yields the expected color
  function automatic void predict_color(input cnsp_in_t ch);
    cnsp_out_t color;
    parse_char(ch.char_code);
    if (!ch.is_last) return;
    if (sp_phase != PH_DONE) finish_spec();
    color = '0;
    if (!sp_failed) begin
      color.matched     = 1'b1;
      color.red_level   = sp_red;
      color.green_level = sp_green;
      color.blue_level  = sp_value;
    end
    expected_colors.push_back(color);
    clear_spec_state();
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building: a spec is assembled in spec_buf, then moved to the feed
  // ---------------------------------------------------------------------------
  logic [7:0]  spec_buf[$];
  feed_entry_t char_feed[$];
  int          chars_queued = 0;
  int          spec_total   = 0;

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) spec_buf.push_back(s[i]);
  endfunction

  // mostly random digits, with all-zero and all-ones often enough to hit the extremes
  function automatic void add_hex_digit();
    int unsigned d;
    d = $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0:       d = 0;
      1:       d = 15;
      default: ;
    endcase
    if (d < 10) spec_buf.push_back(CH_DIGIT_0 + 8'(d));
    else if ($urandom_range(0, 1) != 0) spec_buf.push_back(CH_UPPER_A + 8'(d - 10));
    else spec_buf.push_back(CH_LOWER_A + 8'(d - 10));
  endfunction

  function automatic void build_rgb_spec();
    int unsigned prefix;
    int f;
    int n;
    int i;
    prefix = $urandom_range(0, 3);
    if (prefix > 0) spec_buf.push_back(CH_R);
    if (prefix > 1) spec_buf.push_back(CH_G);
    if (prefix > 2) spec_buf.push_back(CH_B);
    spec_buf.push_back(CH_COLON);
    for (f = 0; f < 3; f++) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) add_hex_digit();
      if (f < 2) spec_buf.push_back(CH_SLASH);
    end
    // trailing text after a closing slash is ignored by the parser
    if ($urandom_range(0, 2) == 0) begin
      spec_buf.push_back(CH_SLASH);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) spec_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_hash_spec();
    int n;
    int i;
    spec_buf.push_back(CH_HASH);
    n = 3 * $urandom_range(1, 4);
    for (i = 0; i < n; i++) add_hex_digit();
  endfunction

  function automatic void build_noise_spec();
    int n;
    int i;
    n = $urandom_range(1, 5);
    if ($urandom_range(0, 4) == 0) spec_buf.push_back(CH_HASH);
    for (i = 0; i < n; i++) spec_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // break a well-formed spec: wrong counts, bad bytes, early ends, lost separators
  function automatic void damage_spec();
    int unsigned pos;
    spec_damage_t how;
    pos = $urandom_range(0, spec_buf.size() - 1);
    how = spec_damage_t'($urandom_range(0, 4));
    case (how)
      DMG_REPLACE: spec_buf[pos] = 8'($urandom_range(0, 255));
      DMG_NUL:     spec_buf.insert($urandom_range(0, spec_buf.size()), CH_NUL);
      DMG_DROP:    spec_buf.delete(pos);
      DMG_REPEAT:  spec_buf.insert(pos, spec_buf[pos]);
      default: begin
        while (spec_buf.size() > pos + 1) spec_buf.delete(spec_buf.size() - 1);
      end
    endcase
    if (spec_buf.size() == 0) spec_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void commit_spec(input bit hold);
    feed_entry_t e;
    int i;
    for (i = 0; i < spec_buf.size(); i++) begin
      e.hold_for_drain = hold && (i == 0);
      e.item.char_code = spec_buf[i];
      e.item.is_last   = (i == spec_buf.size() - 1);
      char_feed.push_back(e);
    end
    chars_queued += spec_buf.size();
    spec_total++;
    spec_buf.delete();
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents the feed one character per transaction, with idle bursts
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_color(in_data);
        char_feed.delete(0);
      end
      // a stalled character stays put; otherwise pick what comes next
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (char_feed.size() == 0 ||
                     (char_feed[0].hold_for_drain && expected_colors.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (char_feed.size() > TAIL_CHARS && (char_feed.size() / 150) % 3 != 0 &&
                     $urandom_range(0, 99) < 12) begin
          // idle burst: this cycle idles and send_gap more follow
          send_gap = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= char_feed[0].item;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transaction against the oldest expected color
  // ---------------------------------------------------------------------------
  int error_count = 0;
  int colors_seen = 0;
  int stall_left  = 0;

  always @(posedge clk) begin
    cnsp_out_t want;
    cnsp_out_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        colors_seen++;
        if (expected_colors.size() == 0) begin
          $error("unexpected result: matched=%0d red=%h green=%h blue=%h",
                 got.matched, got.red_level, got.green_level, got.blue_level);
          error_count++;
        end else begin
          want = expected_colors.pop_front();
          if (got.matched !== want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, got.matched);
            error_count++;
          end
          if (got.red_level !== want.red_level) begin
            $error("red_level: expected %h, got %h", want.red_level, got.red_level);
            error_count++;
          end
          if (got.green_level !== want.green_level) begin
            $error("green_level: expected %h, got %h", want.green_level, got.green_level);
            error_count++;
          end
          if (got.blue_level !== want.blue_level) begin
            $error("blue_level: expected %h, got %h", want.blue_level, got.blue_level);
            error_count++;
          end
        end
      end
      // stall bursts, with calm stretches and none near the end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (colors_seen + TAIL_SPECS < spec_total && (colors_seen / 25) % 3 != 2 &&
                   $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no transaction on either side for too long means a hang
  // ---------------------------------------------------------------------------
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: %0d specs still waiting for a result", expected_colors.size());
        $display("numeric_color_spec_parser verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int  pick;
    bit  hold;
    bit  first_random;
    clear_spec_state();

    // directed: empty spec, short hash form, bare colon form, top byte,
    // spec ending after its first field, zero byte with trailing junk
    spec_buf.push_back(CH_NUL);
    commit_spec(1'b0);
    add_text("#fF0");
    commit_spec(1'b0);
    add_text(":0/9/F");
    commit_spec(1'b0);
    spec_buf.push_back(CH_TOP);
    commit_spec(1'b0);
    add_text("rgb:1/");
    commit_spec(1'b0);
    add_text("#12");
    spec_buf.push_back(CH_NUL);
    add_text("x");
    commit_spec(1'b1);

    // random: mostly well-formed specs, some damaged ones, some noise
    first_random = 1'b1;
    while (chars_queued < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        build_rgb_spec();
      end else if (pick < 70) begin
        build_hash_spec();
      end else if (pick < 92) begin
        if ($urandom_range(0, 1) != 0) build_rgb_spec();
        else build_hash_spec();
        damage_spec();
      end else begin
        build_noise_spec();
      end
      hold = first_random || ($urandom_range(0, 59) == 0);
      commit_spec(hold);
      first_random = 1'b0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (char_feed.size() != 0 || in_valid) @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_ITEMS) @(posedge clk);

    if (error_count == 0) begin
      $display("numeric_color_spec_parser verification clean");
    end else begin
      $display("numeric_color_spec_parser verification failed");
    end
    $finish;
  end

endmodule

>>> numeric_color_spec_parser.f
rtl/cnsp_pkg.sv
rtl/cnsp_field_scale.sv
rtl/cnsp_step.sv
rtl/numeric_color_spec_parser.sv
rtl/cnsp_checker.sv
test/tb_top.sv
